// ===== src/aligned_periodic_report_timer_macros.svh =====
// Assertion macros for the aligned periodic report timer checker.
// Needs nothing else; included by the checker file only.
`ifndef ALIGNED_PERIODIC_REPORT_TIMER_MACROS_SVH
`define ALIGNED_PERIODIC_REPORT_TIMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define APRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aprt assertion failed");

// Next-cycle implication, disabled while reset is high.
`define APRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aprt assertion failed");

`endif

// ===== src/aprt_pkg.sv =====
// Shared types, codes and constants of the aligned periodic report timer.
// No dependencies; used by aprt_step and the top level.
`timescale 1ns / 1ps

package aprt_pkg;

   typedef enum logic [1:0] {
      MODE_BOOT  = 2'd0,
      MODE_IWAIT = 2'd1,
      MODE_AWAIT = 2'd2,
      MODE_READY = 2'd3
   } mode_type;

   localparam logic OP_POLL      = 1'b0;
   localparam logic OP_SEND_DONE = 1'b1;

   localparam int unsigned CSR_INDEX_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALIGN    = 2'd1;

   localparam logic [15:0] MIN_INTERVAL           = 16'd10;
   localparam logic [15:0] MAX_INTERVAL           = 16'd3600;
   localparam logic [15:0] MIN_INTERVAL_FOR_ALIGN = 16'd60;
   localparam logic [5:0]  ALIGN_WINDOW_END       = 6'd10;
   localparam logic [31:0] MAX_ALIGN_WAIT         = 32'd90;
   localparam logic [5:0]  DEFAULT_ALIGN          = 6'd0;
   localparam logic [5:0]  LAST_SECOND            = 6'd59;
   localparam logic [6:0]  SECONDS_PER_MINUTE     = 7'd60;
   localparam logic [15:0] RESET_INTERVAL         = 16'd300;

   typedef struct packed {
      logic [15:0] interval_seconds;
      logic [5:0]  align_second;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] interval_start;
      logic [31:0] align_wait_start;
   } state_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] current_time;
      logic [5:0]  second_of_minute;
      logic        time_synced;
   } item_type;

   typedef struct packed {
      logic        send_now;
      mode_type    mode;
      logic [15:0] seconds_until_send;
   } result_type;

   function automatic logic [15:0] clamp_interval(input logic [15:0] v);
      logic [15:0] r;
      r = v;
      if (v < MIN_INTERVAL) r = MIN_INTERVAL;
      else if (v > MAX_INTERVAL) r = MAX_INTERVAL;
      return r;
   endfunction

   function automatic logic [5:0] clamp_align(input logic [5:0] v);
      return (v > LAST_SECOND) ? DEFAULT_ALIGN : v;
   endfunction

endpackage

// ===== src/aprt_step.sv =====
// Next-state and result logic for one item of the report timer.
// Depends on aprt_pkg.
`timescale 1ns / 1ps

module aprt_step (
   input  aprt_pkg::cfg_type    cfg,
   input  aprt_pkg::state_type  state,
   input  aprt_pkg::item_type   item,
   output aprt_pkg::state_type  next_state,
   output aprt_pkg::result_type result
);

   logic [31:0] elapsed;
   logic [31:0] await_elapsed;
   logic        interval_done;
   logic        timeout;
   logic        aligned;
   logic        skip;
   logic        send_done;
   logic        send;
   logic [31:0] est_elapsed;
   logic        est_done;
   logic [6:0]  wrap_base;
   logic [6:0]  wrap_gap;
   logic [15:0] estimate;

   assign send_done     = (item.opcode == aprt_pkg::OP_SEND_DONE);
   assign elapsed       = item.current_time - state.interval_start;
   assign await_elapsed = item.current_time - state.align_wait_start;
   assign interval_done = (elapsed >= {16'd0, cfg.interval_seconds});
   assign timeout       = (await_elapsed >= aprt_pkg::MAX_ALIGN_WAIT);
   assign aligned       = (item.second_of_minute >= cfg.align_second) &&
                          (item.second_of_minute <= aprt_pkg::ALIGN_WINDOW_END);
   assign skip          = (cfg.interval_seconds < aprt_pkg::MIN_INTERVAL_FOR_ALIGN) ||
                          !item.time_synced;

   always_comb begin
      next_state = state;
      send       = 1'b0;
      priority if (send_done) begin
         next_state.interval_start = item.current_time;
         next_state.mode           = aprt_pkg::MODE_IWAIT;
      end else begin
         unique case (state.mode)
            aprt_pkg::MODE_BOOT, aprt_pkg::MODE_READY: begin
               send = 1'b1;
            end
            aprt_pkg::MODE_IWAIT: begin
               if (interval_done) begin
                  if (skip || aligned) begin
                     next_state.mode = aprt_pkg::MODE_READY;
                     send            = 1'b1;
                  end else begin
                     next_state.mode = aprt_pkg::MODE_AWAIT;
                  end
                  // start of the align wait is recorded even when it ends at once
                  if (!skip) next_state.align_wait_start = item.current_time;
               end
            end
            aprt_pkg::MODE_AWAIT: begin
               if (timeout || aligned) begin
                  next_state.mode = aprt_pkg::MODE_READY;
                  send            = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Estimate from the mode after the step; a send-done restarts the interval.
   assign est_elapsed = send_done ? 32'd0 : elapsed;
   assign est_done    = (est_elapsed >= {16'd0, cfg.interval_seconds});
   assign wrap_base   = aprt_pkg::SECONDS_PER_MINUTE + {1'b0, cfg.align_second};
   assign wrap_gap    = wrap_base - {1'b0, item.second_of_minute};

   always_comb begin
      estimate = 16'd0;
      unique case (next_state.mode)
         aprt_pkg::MODE_IWAIT: begin
            if (!est_done) begin
               estimate = cfg.interval_seconds - est_elapsed[15:0];
            end else if (!skip && (item.second_of_minute < cfg.align_second)) begin
               estimate = {10'd0, cfg.align_second - item.second_of_minute};
            end
         end
         aprt_pkg::MODE_AWAIT: begin
            if (aligned) begin
               estimate = 16'd0;
            end else if (item.second_of_minute < cfg.align_second) begin
               estimate = {10'd0, cfg.align_second - item.second_of_minute};
            end else if ({1'b0, item.second_of_minute} <= wrap_base) begin
               estimate = {9'd0, wrap_gap};
            end
         end
         default: estimate = 16'd0;
      endcase
   end

   assign result.send_now           = send;
   assign result.mode               = next_state.mode;
   assign result.seconds_until_send = estimate;

endmodule

// ===== src/aligned_periodic_report_timer.sv =====
// Top level of the aligned periodic report timer: handshakes, state and result register.
// Depends on aprt_pkg and aprt_step.
`timescale 1ns / 1ps

// Aligned periodic report timer.
// The req_ channel carries one item per poll or per completed send: req_tuser is
// the opcode (poll or send done), req_tdata the time fields. For every item the
// rsp_ channel returns one item with the send decision, the mode after the step
// and an estimate of the seconds left until the next send.
// The csr_ channel writes the interval (index 0) and the aligned second (index 1);
// values are clamped as they are written. Write it only while the block is idle.
// An accepted item sits in the input register; its result is computed by
// aprt_step and lands in the result register once the output side is free,
// and rsp_tvalid rises as the result register is loaded.
// Throughput: one item per cycle while the output side is not stalled; the state
// update is a single pass through aprt_step (two 32-bit subtract-and-compare
// paths) between the input register and the state and result registers.
// A stalled rsp_tready holds the result register; the input register still takes
// one more item, then req_tready drops until the result is taken.
// Reset (synchronous, active high) empties both registers, sets the mode to boot,
// clears the timestamps, loads interval 300 and aligned second 0, and holds
// req_tready and csr_ready low.

module aligned_periodic_report_timer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // current_time[31:0], second_of_minute[37:32],
                                    // time_synced[38], zero[39]
   input  logic        req_tuser,   // opcode[0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // send_now[0], mode[2:1],
                                    // seconds_until_send[18:3], zero[23:19]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [aprt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);

   aprt_pkg::cfg_type    cfg_ff, cfg_in;
   aprt_pkg::state_type  state_ff, state_next;
   aprt_pkg::item_type   item_ff, item_in;
   aprt_pkg::result_type rsp_data_ff, step_result;
   logic                 item_valid_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 req_fire;

   // the result register frees when empty or taken this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !reset && (!item_valid_ff || advance);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   assign item_in.opcode           = req_tuser;
   assign item_in.current_time     = req_tdata[31:0];
   assign item_in.second_of_minute = req_tdata[37:32];
   assign item_in.time_synced      = req_tdata[38];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == aprt_pkg::CSR_INTERVAL) begin
            cfg_in.interval_seconds = aprt_pkg::clamp_interval(csr_data);
         end else if (csr_index == aprt_pkg::CSR_ALIGN) begin
            cfg_in.align_second = aprt_pkg::clamp_align(csr_data[5:0]);
         end
      end
   end

   aprt_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .next_state (state_next),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_seconds <= aprt_pkg::clamp_interval(aprt_pkg::RESET_INTERVAL);
         cfg_ff.align_second     <= aprt_pkg::clamp_align(aprt_pkg::DEFAULT_ALIGN);
         state_ff.mode             <= aprt_pkg::MODE_BOOT;
         state_ff.interval_start   <= 32'd0;
         state_ff.align_wait_start <= 32'd0;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         // move the held item into the result register and commit its state
         if (advance) begin
            rsp_valid_ff <= item_valid_ff;
            if (item_valid_ff) state_ff <= state_next;
         end
         if (req_fire) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_fire) item_ff <= item_in;
      if (advance && item_valid_ff) rsp_data_ff <= step_result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.seconds_until_send,
                        rsp_data_ff.mode, rsp_data_ff.send_now};

endmodule

// ===== src/aprt_checker.sv =====
// Port-level checker for the aligned periodic report timer, bound to the top level.
// Depends on aprt_pkg and aligned_periodic_report_timer_macros.svh.
`timescale 1ns / 1ps
`include "aligned_periodic_report_timer_macros.svh"

module aprt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic        send_now;
   logic [1:0]  mode;
   logic [15:0] secs;
   logic [4:0]  pad;

   assign send_now = rsp_tdata[0];
   assign mode     = rsp_tdata[2:1];
   assign secs     = rsp_tdata[18:3];
   assign pad      = rsp_tdata[23:19];

   // a stalled result holds
   `APRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // a send is only granted in boot or ready
   `APRT_ASSERT_NOW(a_send_mode, clock, reset, rsp_tvalid && send_now,
      (mode == aprt_pkg::MODE_BOOT) || (mode == aprt_pkg::MODE_READY))

   // boot always sends and has nothing left to wait
   `APRT_ASSERT_NOW(a_boot_sends, clock, reset,
      rsp_tvalid && (mode == aprt_pkg::MODE_BOOT), send_now && (secs == 16'd0))

   // the wait modes never grant a send
   `APRT_ASSERT_NOW(a_wait_blocks, clock, reset,
      rsp_tvalid && ((mode == aprt_pkg::MODE_IWAIT) || (mode == aprt_pkg::MODE_AWAIT)),
      !send_now)

   // the pad above the result fields reads as zero
   `APRT_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, pad == 5'd0)

endmodule

bind aligned_periodic_report_timer aprt_checker u_aprt_checker (.*);

// ===== bench/tb_aligned_periodic_report_timer.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the aligned periodic report timer: directed items, then random phases.
// Depends on aprt_pkg and the aligned_periodic_report_timer top level; nothing else.

module tb_aligned_periodic_report_timer;
   import aprt_pkg::*;

   // Longest correct stretch without any handshake is the long result hold
   // (LONG_HOLD) plus a few gaps. Allow several times that before giving up.
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned MAX_GAP      = 8;
   // Settling wait at the end, after every owed result has come back.
   localparam int unsigned DRAIN_CYCLES = 8;

   // Tracks the send schedule the block should follow and the results it owes.
   class send_schedule;
      logic [15:0] interval_reg;
      logic [5:0]  align_reg;
      mode_type    mode_now;
      logic [31:0] interval_start;
      logic [31:0] align_start;
      result_type  due_results[$];
      int unsigned mismatches;

      function new();
         interval_reg   = RESET_INTERVAL;
         align_reg      = 6'd0;
         mode_now       = MODE_BOOT;
         interval_start = 32'd0;
         align_start    = 32'd0;
         mismatches     = 0;
      endfunction

      // Clamp as the block does when a register is written.
      function void write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] data);
         if (index == CSR_INTERVAL) begin
            if (data < MIN_INTERVAL) interval_reg = MIN_INTERVAL;
            else if (data > MAX_INTERVAL) interval_reg = MAX_INTERVAL;
            else interval_reg = data;
         end else if (index == CSR_ALIGN) begin
            align_reg = (data[5:0] > LAST_SECOND) ? DEFAULT_ALIGN : data[5:0];
         end
      endfunction

      function bit in_window(input logic [5:0] sec);
         return (sec >= align_reg) && (sec <= ALIGN_WINDOW_END);
      endfunction

      function bit align_skipped(input logic synced);
         return (interval_reg < MIN_INTERVAL_FOR_ALIGN) || !synced;
      endfunction

      // Estimate from the mode after the step.
      function logic [15:0] seconds_left(input item_type it);
         logic [31:0] elapsed;
         int unsigned sec;
         int unsigned al;
         sec     = it.second_of_minute;
         al      = align_reg;
         elapsed = it.current_time - interval_start;
         case (mode_now)
            MODE_IWAIT: begin
               if (elapsed >= {16'd0, interval_reg}) begin
                  if (align_skipped(it.time_synced) || sec >= al) return 16'd0;
                  return 16'(al - sec);
               end
               return 16'(interval_reg - elapsed[15:0]);
            end
            MODE_AWAIT: begin
               if (in_window(it.second_of_minute)) return 16'd0;
               if (sec < al) return 16'(al - sec);
               // seconds past 59 can push the wrap estimate negative: clamp
               if (sec > SECONDS_PER_MINUTE + al) return 16'd0;
               return 16'(SECONDS_PER_MINUTE - sec + al);
            end
            default: return 16'd0;
         endcase
      endfunction

      // Advance the schedule by one accepted item and queue the result it owes.
      function void note_item(input item_type it);
         result_type  want;
         logic [31:0] elapsed;
         want.send_now = 1'b0;
         if (it.opcode == OP_SEND_DONE) begin
            interval_start = it.current_time;
            mode_now       = MODE_IWAIT;
         end else begin
            case (mode_now)
               MODE_BOOT, MODE_READY: want.send_now = 1'b1;
               MODE_IWAIT: begin
                  elapsed = it.current_time - interval_start;
                  if (elapsed >= {16'd0, interval_reg}) begin
                     if (align_skipped(it.time_synced)) begin
                        mode_now      = MODE_READY;
                        want.send_now = 1'b1;
                     end else begin
                        mode_now    = MODE_AWAIT;
                        align_start = it.current_time;
                        if (in_window(it.second_of_minute)) begin
                           mode_now      = MODE_READY;
                           want.send_now = 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  elapsed = it.current_time - align_start;
                  if (elapsed >= MAX_ALIGN_WAIT || in_window(it.second_of_minute)) begin
                     mode_now      = MODE_READY;
                     want.send_now = 1'b1;
                  end
               end
            endcase
         end
         want.mode               = mode_now;
         want.seconds_until_send = seconds_left(it);
         due_results.push_back(want);
      endfunction

      task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
         mismatches++;
         if (mismatches <= 100)
            $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
      endtask

      // Compare one accepted result item with the oldest owed result.
      task check_result(input logic [23:0] raw);
         result_type want;
         if (due_results.size() == 0) begin
            report_mismatch("unexpected result item", {8'd0, raw}, 32'd0);
         end else begin
            want = due_results.pop_front();
            if (raw[0] !== want.send_now)
               report_mismatch("send_now", {31'd0, raw[0]}, {31'd0, want.send_now});
            if (raw[2:1] !== want.mode)
               report_mismatch("mode", {30'd0, raw[2:1]}, {30'd0, want.mode});
            if (raw[18:3] !== want.seconds_until_send)
               report_mismatch("seconds_until_send", {16'd0, raw[18:3]},
                               {16'd0, want.seconds_until_send});
         end
      endtask
   endclass

   // Every block input holds a known value from time zero.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // current_time[31:0], second_of_minute[37:32],
                                   // time_synced[38], zero[39]
   logic        req_tuser  = 1'b0; // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // send_now[0], mode[2:1],
                                   // seconds_until_send[18:3], zero[23:19]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0] csr_data   = '0;

   send_schedule tracker = new();

   // Shared pacing controls, set per phase by the stimulus process.
   bit no_idle      = 1'b0;
   bit hold_results = 1'b0;

   // Running wall clock for the random items.
   logic [31:0] stim_time = 32'hFFFF_F000;
   int unsigned stim_sec  = 0;

   int unsigned idle_cycles = 0;

   always #2 clock = ~clock;

   aligned_periodic_report_timer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Offer one item, after a random gap unless no_idle is set; hold it until the block takes it.
   // Valid stays high on return so a back-to-back item is offered without a drop in valid.
   task automatic push_item(input item_type it);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.opcode;
      req_tdata  <= {1'b0, it.time_synced, it.second_of_minute, it.current_time};
      do @(posedge clock); while (!req_tready);
      tracker.note_item(it);
   endtask

   task automatic directed(input logic op, input logic [31:0] t, input logic [5:0] sec,
                           input logic synced);
      item_type it;
      it.opcode           = op;
      it.current_time     = t;
      it.second_of_minute = sec;
      it.time_synced      = synced;
      push_item(it);
   endtask

   // Build the next random item. Mostly a plausible wall clock that creeps
   // forward, with jumps onto the interval and align-timeout boundaries so the
   // schedule keeps moving through all its modes; some noise on top.
   function automatic item_type next_item();
      item_type    it;
      logic [31:0] next_time;
      logic [31:0] delta;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         next_time = stim_time + $urandom_range(0, 3);
      end else if (pick < 70) begin
         next_time = stim_time + $urandom_range(0, tracker.interval_reg / 4 + 1);
      end else if (pick < 88) begin
         if (tracker.mode_now == MODE_IWAIT)
            next_time = tracker.interval_start + tracker.interval_reg + $urandom_range(0, 2) - 1;
         else if (tracker.mode_now == MODE_AWAIT)
            next_time = tracker.align_start + MAX_ALIGN_WAIT + $urandom_range(0, 1) - 1;
         else
            next_time = stim_time + $urandom_range(0, 3);
      end else if (pick < 94) begin
         next_time = $urandom;
      end else begin
         next_time = stim_time + $urandom_range(0, 65535);
      end
      // keep the second of minute in step with the counter
      delta     = next_time - stim_time;
      stim_sec  = (stim_sec + delta % 60) % 60;
      stim_time = next_time;

      it.current_time     = next_time;
      it.second_of_minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'(stim_sec);
      it.time_synced      = ($urandom_range(0, 11) != 0);
      // after a send is due, mostly report it done; otherwise mostly poll
      if (tracker.mode_now == MODE_BOOT || tracker.mode_now == MODE_READY)
         it.opcode = ($urandom_range(0, 3) != 0) ? OP_SEND_DONE : OP_POLL;
      else
         it.opcode = ($urandom_range(0, 24) == 0) ? OP_SEND_DONE : OP_POLL;
      return it;
   endfunction

   // Drop the request valid and wait until every owed result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.due_results.size() != 0) @(posedge clock);
   endtask

   // Settle the block, write both registers back to back, then run random items.
   task automatic run_phase(input logic [15:0] interval_data, input logic [15:0] align_data,
                            input int unsigned count, input bit quiet, input bit hold);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_INTERVAL;
      csr_data  <= interval_data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(CSR_INTERVAL, interval_data);
      csr_index <= CSR_ALIGN;
      csr_data  <= align_data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(CSR_ALIGN, align_data);
      csr_valid <= 1'b0;
      no_idle      = quiet;
      hold_results = hold;
      repeat (count) push_item(next_item());
   endtask

   // Result side: random back-pressure per item, plus one long hold on request
   // so the block fills and stalls its input while the sender keeps offering.
   initial begin : take_results
      int unsigned gap;
      wait (reset == 1'b0);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_result(rsp_tdata);
      end
   end

   // Watchdog: end the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset settings: interval 300, aligned second 0.
      directed(OP_POLL,      32'd0,          6'd0,  1'b1); // boot poll sends
      directed(OP_POLL,      32'hFFFF_FFFF,  6'd63, 1'b0); // field extremes in boot
      directed(OP_SEND_DONE, 32'hFFFF_FF00,  6'd0,  1'b1); // interval starts near wrap
      directed(OP_POLL,      32'h0000_002B,  6'd30, 1'b1); // one second short, across wrap
      directed(OP_POLL,      32'h0000_002C,  6'd5,  1'b1); // elapsed, already aligned
      directed(OP_POLL,      32'h0000_002D,  6'd6,  1'b1); // ready keeps sending
      directed(OP_SEND_DONE, 32'd1000,       6'd20, 1'b1);
      directed(OP_POLL,      32'd1300,       6'd30, 1'b1); // enter align wait
      directed(OP_POLL,      32'd1301,       6'd61, 1'b1); // second past 59, estimate clamps
      directed(OP_POLL,      32'd1302,       6'd63, 1'b1);
      directed(OP_POLL,      32'd1303,       6'd59, 1'b1); // wrap estimate
      directed(OP_POLL,      32'd1389,       6'd20, 1'b1); // one short of timeout
      directed(OP_POLL,      32'd1390,       6'd21, 1'b1); // align timeout
      directed(OP_SEND_DONE, 32'd2000,       6'd0,  1'b1);
      directed(OP_POLL,      32'd2300,       6'd30, 1'b0); // unsynced skips alignment
      directed(OP_SEND_DONE, 32'd3000,       6'd0,  1'b1);
      directed(OP_POLL,      32'd3300,       6'd10, 1'b1); // window end is aligned
      directed(OP_SEND_DONE, 32'd4000,       6'd0,  1'b1);
      directed(OP_POLL,      32'd4300,       6'd11, 1'b1); // just past the window
      directed(OP_POLL,      32'd4301,       6'd0,  1'b1); // window start
      directed(OP_SEND_DONE, 32'd4302,       6'd1,  1'b1); // send done while ready
      directed(OP_SEND_DONE, 32'd5000,       6'd2,  1'b1); // send done while waiting
      directed(OP_POLL,      32'd4999,       6'd40, 1'b1); // time went back: huge elapsed
      directed(OP_SEND_DONE, 32'd6000,       6'd41, 1'b1); // send done in align wait
      stim_time = 32'd6000;
      stim_sec  = 41;

      // Random phases; the settings sweep both register extremes and the
      // corners of the align window.
      run_phase(16'd300,   16'd0,  120, 1'b0, 1'b0);
      run_phase(16'd0,     16'd0,  110, 1'b0, 1'b0); // interval clamps up
      run_phase(16'hFFFF,  16'd63, 110, 1'b1, 1'b0); // both clamp, no idling
      run_phase(16'd60,    16'd10, 110, 1'b1, 1'b1); // long result hold
      run_phase(16'd59,    16'd5,  100, 1'b0, 1'b0); // too short to align
      run_phase(16'd120,   16'd45, 110, 1'b0, 1'b0); // never aligned, timeout only
      run_phase(16'd9,     16'd60, 90,  1'b0, 1'b0);
      run_phase(16'd3600,  16'd59, 110, 1'b0, 1'b0);
      run_phase(16'd11,    16'd11, 90,  1'b0, 1'b0);
      repeat (5)
         run_phase(16'($urandom_range(0, 400)), 16'($urandom_range(0, 63)), 90,
                   ($urandom_range(0, 3) == 0), 1'b0);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
